### sv/bwbd_pkg.sv
// bwbd_pkg: shared constants for the bar-width barcode decoder
// register indexes, reset values and default sizing; no dependencies

package bwbd_pkg;

    // default sizing
    localparam int unsigned MAX_LINE_SAMPLES = 4096;
    localparam int unsigned NUMBER_BITS      = 20;
    localparam int unsigned CHECK_WIDTH      = 3;

    // configuration register file
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_GAP_LIMIT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] LEVEL_THRESHOLD_RST = 8'd128;
    localparam logic [CFG_DATA_W-1:0] QUIET_GAP_LIMIT_RST = 8'd10;

    // sample payload width
    localparam int unsigned LEVEL_W = 8;

endpackage

### sv/bar_width_barcode_decoder_unit.sv
// bar_width_barcode_decoder_unit: top level of the scan-line bar-width decoder
// input register, config registers and result register around bwbd_line_core
// depends on bwbd_pkg and bwbd_line_core
//
//  channel   valid        stall        payload
//  -------   ----------   ----------   -------------------------------------------
//  sample    i_in_valid   o_in_stall   i_sample_level, i_line_end
//  result    o_out_valid  i_out_stall  o_decoded_number, o_check_bits,
//                                      o_symbols_seen, o_check_match
//  config    i_cfg_we     (none)       i_cfg_index, i_cfg_data
//
// one item per cycle while the sample side is not stalled; a result passes the input
// register, then the result register behind the line-state update
// the sample side stalls only while a line-end item waits on a full, stalled
// result register; other samples keep flowing
// synchronous active-low reset clears line state, handshakes and config

module bar_width_barcode_decoder_unit #(
    parameter int unsigned MAX_LINE_SAMPLES = bwbd_pkg::MAX_LINE_SAMPLES,
    parameter int unsigned NUMBER_BITS      = bwbd_pkg::NUMBER_BITS,
    parameter int unsigned CHECK_WIDTH      = bwbd_pkg::CHECK_WIDTH,
    localparam int unsigned SYM_W           = $clog2(NUMBER_BITS + CHECK_WIDTH + 2)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bwbd_pkg::LEVEL_W-1:0]    i_sample_level,
    input  logic                            i_line_end,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [NUMBER_BITS-1:0]          o_decoded_number,
    output logic [CHECK_WIDTH-1:0]          o_check_bits,
    output logic [SYM_W-1:0]                o_symbols_seen,
    output logic                            o_check_match,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [bwbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bwbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [bwbd_pkg::CFG_DATA_W-1:0] r_level_threshold;
    logic [bwbd_pkg::CFG_DATA_W-1:0] r_quiet_gap_limit;

    logic                         r_s1_valid;
    logic [bwbd_pkg::LEVEL_W-1:0] r_s1_level;
    logic                         r_s1_line_end;

    logic                   r_out_valid;
    logic [NUMBER_BITS-1:0] r_number;
    logic [CHECK_WIDTH-1:0] r_check;
    logic [SYM_W-1:0]       r_symbols;
    logic                   r_match;

    logic                   w_commit;
    logic                   w_in_acc;
    logic                   w_out_load;
    logic [NUMBER_BITS-1:0] w_number;
    logic [CHECK_WIDTH-1:0] w_check;
    logic [SYM_W-1:0]       w_symbols;
    logic                   w_match;

    // handshake: the held item advances unless its result has nowhere to go
    assign w_commit   = r_s1_valid && !(r_s1_line_end && r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !w_commit;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = w_commit && r_s1_line_end;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_threshold <= bwbd_pkg::LEVEL_THRESHOLD_RST;
            r_quiet_gap_limit <= bwbd_pkg::QUIET_GAP_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bwbd_pkg::REG_LEVEL_THRESHOLD: r_level_threshold <= i_cfg_data;
                bwbd_pkg::REG_QUIET_GAP_LIMIT: r_quiet_gap_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc || (r_s1_valid && !w_commit);
        end
        if (w_in_acc) begin
            r_s1_level    <= i_sample_level;
            r_s1_line_end <= i_line_end;
        end
    end

    // line state and bit collection
    bwbd_line_core #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
        .NUMBER_BITS      (NUMBER_BITS),
        .CHECK_WIDTH      (CHECK_WIDTH)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_commit          (w_commit),
        .i_level           (r_s1_level),
        .i_line_end        (r_s1_line_end),
        .i_level_threshold (r_level_threshold),
        .i_quiet_gap_limit (r_quiet_gap_limit),
        .o_decoded_number  (w_number),
        .o_check_bits      (w_check),
        .o_symbols_seen    (w_symbols),
        .o_check_match     (w_match)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_number  <= w_number;
            r_check   <= w_check;
            r_symbols <= w_symbols;
            r_match   <= w_match;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_decoded_number = r_number;
    assign o_check_bits     = r_check;
    assign o_symbols_seen   = r_symbols;
    assign o_check_match    = r_match;

    // a new result only follows a committed line-end item
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_commit && r_s1_line_end))
        else $error("result without a line-end item");

    // the sample side stalls only with an item held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_s1_line_end && r_out_valid && i_out_stall)
        else $error("input stalled without cause");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !w_out_load)
        else $error("stalled result overwritten");

endmodule

### sv/bwbd_line_core.sv
// bwbd_line_core: per-line edge tracking, run lengths and bit collection
// holds the line state and forms the result fields; depends on bwbd_pkg

module bwbd_line_core #(
    parameter int unsigned MAX_LINE_SAMPLES = bwbd_pkg::MAX_LINE_SAMPLES,
    parameter int unsigned NUMBER_BITS      = bwbd_pkg::NUMBER_BITS,
    parameter int unsigned CHECK_WIDTH      = bwbd_pkg::CHECK_WIDTH,
    localparam int unsigned TOTAL_BITS      = NUMBER_BITS + CHECK_WIDTH,
    localparam int unsigned SYM_W           = $clog2(TOTAL_BITS + 2)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_commit,
    input  logic [bwbd_pkg::LEVEL_W-1:0]    i_level,
    input  logic                            i_line_end,
    input  logic [bwbd_pkg::CFG_DATA_W-1:0] i_level_threshold,
    input  logic [bwbd_pkg::CFG_DATA_W-1:0] i_quiet_gap_limit,
    output logic [NUMBER_BITS-1:0]          o_decoded_number,
    output logic [CHECK_WIDTH-1:0]          o_check_bits,
    output logic [SYM_W-1:0]                o_symbols_seen,
    output logic                            o_check_match
);

    localparam int unsigned POS_W   = $clog2(MAX_LINE_SAMPLES);
    localparam int unsigned CMP_W   = (POS_W > bwbd_pkg::CFG_DATA_W) ? POS_W
                                                                     : bwbd_pkg::CFG_DATA_W;
    localparam int unsigned LOW_W   = (NUMBER_BITS < CHECK_WIDTH) ? NUMBER_BITS : CHECK_WIDTH;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE_SAMPLES - 1);

    logic [bwbd_pkg::LEVEL_W-1:0] r_prev_level;
    logic [POS_W-1:0]             r_position;
    logic [POS_W-1:0]             r_bar_mark;
    logic [POS_W-1:0]             r_gap_mark;
    logic [SYM_W-1:0]             r_symbol;
    logic [TOTAL_BITS-1:0]        r_bits;

    logic [POS_W-1:0]      n_bar_mark;
    logic [POS_W-1:0]      n_gap_mark;
    logic [SYM_W-1:0]      n_symbol;
    logic [TOTAL_BITS-1:0] n_bits;

    logic [POS_W-1:0] w_pos;
    logic [POS_W-1:0] w_gap;
    logic [POS_W-1:0] w_bar_len;
    logic             w_was_white;
    logic             w_is_white;
    logic             w_active;

    // edge position, colors and run lengths clamped at zero
    assign w_pos       = r_position - POS_W'(1);
    assign w_was_white = r_prev_level > i_level_threshold;
    assign w_is_white  = i_level > i_level_threshold;
    assign w_active    = (r_position != '0) && (r_symbol <= SYM_W'(TOTAL_BITS));
    assign w_gap       = (w_pos >= r_gap_mark) ? (w_pos - r_gap_mark) : '0;
    assign w_bar_len   = (w_pos >= r_bar_mark) ? (w_pos - r_bar_mark) : '0;

    // next line state for this item
    always_comb begin
        n_bar_mark = r_bar_mark;
        n_gap_mark = r_gap_mark;
        n_symbol   = r_symbol;
        n_bits     = r_bits;
        if (w_active && w_was_white && !w_is_white) begin
            // white-to-black: short gap adds a symbol, quiet gap restarts
            if (CMP_W'(w_gap) < CMP_W'(i_quiet_gap_limit)) begin
                n_symbol = r_symbol + SYM_W'(1);
                for (int k = 0; k < TOTAL_BITS; k++) begin
                    if (r_symbol == SYM_W'(k)) begin
                        n_bits[k] = r_bar_mark > w_gap;
                    end
                end
            end else begin
                n_symbol = '0;
            end
            n_bar_mark = w_pos + POS_W'(1);
        end else if (w_active && !w_was_white && w_is_white) begin
            // black-to-white: bar mark turns into the bar length
            n_bar_mark = w_bar_len;
            n_gap_mark = w_pos + POS_W'(1);
        end
    end

    // result fields from the updated store
    assign o_decoded_number = n_bits[NUMBER_BITS-1:0];
    assign o_check_bits     = n_bits[TOTAL_BITS-1:NUMBER_BITS];
    assign o_symbols_seen   = n_symbol;
    assign o_check_match    = o_check_bits == CHECK_WIDTH'(o_decoded_number[LOW_W-1:0]);

    // line state, cleared after the last sample of each line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= '0;
            r_position   <= '0;
            r_bar_mark   <= '0;
            r_gap_mark   <= '0;
            r_symbol     <= '0;
            r_bits       <= '0;
        end else if (i_commit) begin
            if (i_line_end) begin
                r_prev_level <= '0;
                r_position   <= '0;
                r_bar_mark   <= '0;
                r_gap_mark   <= '0;
                r_symbol     <= '0;
                r_bits       <= '0;
            end else begin
                r_prev_level <= i_level;
                if (r_position != POS_LAST) begin
                    r_position <= r_position + POS_W'(1);
                end
                r_bar_mark <= n_bar_mark;
                r_gap_mark <= n_gap_mark;
                r_symbol   <= n_symbol;
                r_bits     <= n_bits;
            end
        end
    end

    // symbol count stops one past the store size
    a_symbol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_symbol <= SYM_W'(TOTAL_BITS + 1))
        else $error("symbol count beyond limit");

    // a line end leaves the line state cleared
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && i_line_end |=> r_position == '0 && r_bits == '0 && r_symbol == '0)
        else $error("line state not cleared after line end");

    // no edge is taken while collection is full
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && !i_line_end && r_symbol > SYM_W'(TOTAL_BITS) |=> $stable(r_bits)
            && $stable(r_symbol))
        else $error("collection changed after it was full");

endmodule

### bench/decode_result_checker.sv
// decode_result_checker: watches the sample, result and config channels of the decoder
// keeps its own copy of the line state, predicts each line result and compares it
// depends on bwbd_pkg
`timescale 1ns / 100ps

module decode_result_checker #(
    localparam int unsigned NUMBER_BITS = bwbd_pkg::NUMBER_BITS,
    localparam int unsigned CHECK_WIDTH = bwbd_pkg::CHECK_WIDTH,
    localparam int unsigned LEVEL_W     = bwbd_pkg::LEVEL_W,
    localparam int unsigned CFG_IDX_W   = bwbd_pkg::CFG_IDX_W,
    localparam int unsigned CFG_DATA_W  = bwbd_pkg::CFG_DATA_W,
    localparam int unsigned SYM_W       = $clog2(NUMBER_BITS + CHECK_WIDTH + 2)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample channel
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [LEVEL_W-1:0]      i_sample_level,
    input  logic                    i_line_end,
    // result channel
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [NUMBER_BITS-1:0]  i_decoded_number,
    input  logic [CHECK_WIDTH-1:0]  i_check_bits,
    input  logic [SYM_W-1:0]        i_symbols_seen,
    input  logic                    i_check_match,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // status to the top
    output int                      o_mismatch_count,
    output int                      o_lines_pending
);

    localparam int unsigned TOTAL_BITS = NUMBER_BITS + CHECK_WIDTH;
    localparam int unsigned POS_MAX    = bwbd_pkg::MAX_LINE_SAMPLES - 1;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] number;
        logic [CHECK_WIDTH-1:0] check;
        logic [SYM_W-1:0]       symbols;
        logic                   match;
    } t_line_result;

    // decoder configuration as last written
    logic [CFG_DATA_W-1:0] level_thr;
    logic [CFG_DATA_W-1:0] quiet_limit;

    // line state
    logic [LEVEL_W-1:0]    prev_level;
    logic [11:0]           position;
    logic [11:0]           bar_mark;
    logic [11:0]           gap_mark;
    logic [SYM_W-1:0]      sym_count;
    logic [TOTAL_BITS-1:0] decoded_bits;

    t_line_result pending_lines[$];
    t_line_result want;

    // length from a mark up to now, floored at zero
    function automatic logic [11:0] span(input logic [11:0] now, input logic [11:0] mark);
        return (now >= mark) ? now - mark : 12'd0;
    endfunction

    function automatic void clear_line_state();
        prev_level   = '0;
        position     = '0;
        bar_mark     = '0;
        gap_mark     = '0;
        sym_count    = '0;
        decoded_bits = '0;
    endfunction

    // one accepted sample: edge detection, bit collection, result on line end
    function automatic void step_scan_line(input logic [LEVEL_W-1:0] lvl, input logic last);
        logic [11:0]  edge_pos;
        logic [11:0]  gap_len;
        logic         was_white;
        logic         is_white;
        t_line_result res;
        if (position != 0 && sym_count <= TOTAL_BITS) begin
            edge_pos  = position - 12'd1;
            was_white = prev_level > level_thr;
            is_white  = lvl > level_thr;
            if (was_white && !is_white) begin
                gap_len = span(edge_pos, gap_mark);
                if (gap_len < quiet_limit) begin
                    sym_count = sym_count + 1'b1;
                    if (sym_count <= TOTAL_BITS)
                        decoded_bits[sym_count - 1] = (bar_mark > gap_len);
                end else begin
                    sym_count = '0;
                end
                bar_mark = edge_pos + 12'd1;
            end else if (!was_white && is_white) begin
                bar_mark = span(edge_pos, bar_mark);
                gap_mark = edge_pos + 12'd1;
            end
        end
        prev_level = lvl;
        if (position < POS_MAX)
            position = position + 12'd1;
        if (last) begin
            res.number  = decoded_bits[NUMBER_BITS-1:0];
            res.check   = decoded_bits[TOTAL_BITS-1:NUMBER_BITS];
            res.symbols = sym_count;
            res.match   = (res.check == res.number[CHECK_WIDTH-1:0]);
            pending_lines = {pending_lines, res};
            clear_line_state();
        end
    endfunction

    // channel monitor: results are compared before a new line is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level_thr   = bwbd_pkg::LEVEL_THRESHOLD_RST;
            quiet_limit = bwbd_pkg::QUIET_GAP_LIMIT_RST;
            clear_line_state();
            pending_lines.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bwbd_pkg::REG_LEVEL_THRESHOLD: level_thr   = i_cfg_data;
                    bwbd_pkg::REG_QUIET_GAP_LIMIT: quiet_limit = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_lines.size() == 0) begin
                    $error("result item with no line pending");
                    o_mismatch_count++;
                end else begin
                    want = pending_lines.pop_front();
                    if (i_decoded_number !== want.number) begin
                        $error("decoded_number: expected %0d, got %0d",
                               want.number, i_decoded_number);
                        o_mismatch_count++;
                    end
                    if (i_check_bits !== want.check) begin
                        $error("check_bits: expected %0d, got %0d", want.check, i_check_bits);
                        o_mismatch_count++;
                    end
                    if (i_symbols_seen !== want.symbols) begin
                        $error("symbols_seen: expected %0d, got %0d",
                               want.symbols, i_symbols_seen);
                        o_mismatch_count++;
                    end
                    if (i_check_match !== want.match) begin
                        $error("check_match: expected %0d, got %0d", want.match, i_check_match);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                step_scan_line(i_sample_level, i_line_end);
        end
        o_lines_pending = pending_lines.size();
    end

    initial begin
        o_mismatch_count = 0;
        o_lines_pending  = 0;
    end

endmodule

### bench/testbench.sv
// testbench: scan-line stimulus and verdict for bar_width_barcode_decoder_unit
// drives sample lines, config phases and result back-pressure; decode_result_checker checks
// depends on bwbd_pkg, decode_result_checker and the decoder RTL
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned NUMBER_BITS = bwbd_pkg::NUMBER_BITS;
    localparam int unsigned CHECK_WIDTH = bwbd_pkg::CHECK_WIDTH;
    localparam int unsigned LEVEL_W     = bwbd_pkg::LEVEL_W;
    localparam int unsigned CFG_IDX_W   = bwbd_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W  = bwbd_pkg::CFG_DATA_W;
    localparam int unsigned SYM_W       = $clog2(NUMBER_BITS + CHECK_WIDTH + 2);

    typedef enum {LINE_CODE, LINE_BROKEN, LINE_NOISE} t_line_kind;

    logic                   i_clk;
    logic                   i_rst_n          = 1'b0;
    logic                   i_in_valid       = 1'b0;
    logic                   o_in_stall;
    logic [LEVEL_W-1:0]     i_sample_level   = '0;
    logic                   i_line_end       = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall      = 1'b0;
    logic [NUMBER_BITS-1:0] o_decoded_number;
    logic [CHECK_WIDTH-1:0] o_check_bits;
    logic [SYM_W-1:0]       o_symbols_seen;
    logic                   o_check_match;
    logic                   i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data       = '0;

    int mismatch_count;
    int lines_pending;

    // stimulus control
    logic [CFG_DATA_W-1:0] cur_thr   = bwbd_pkg::LEVEL_THRESHOLD_RST;
    logic [CFG_DATA_W-1:0] cur_quiet = bwbd_pkg::QUIET_GAP_LIMIT_RST;
    logic [LEVEL_W-1:0]    line_q[$];
    int                    items_sent = 0;
    int                    idle_pct   = 0;
    bit                    idling     = 1'b1;
    bit                    long_hold  = 1'b0;

    bar_width_barcode_decoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample_level   (i_sample_level),
        .i_line_end       (i_line_end),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_decoded_number (o_decoded_number),
        .o_check_bits     (o_check_bits),
        .o_symbols_seen   (o_symbols_seen),
        .o_check_match    (o_check_match),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    decode_result_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_sample_level   (i_sample_level),
        .i_line_end       (i_line_end),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_decoded_number (o_decoded_number),
        .i_check_bits     (o_check_bits),
        .i_symbols_seen   (o_symbols_seen),
        .i_check_match    (o_check_match),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_lines_pending  (lines_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAIL bar_width_barcode_decoder_unit");
        $finish;
    end

    // result side back-pressure: random bursts, one long hold on request
    initial begin
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [LEVEL_W-1:0] white_level();
        if (cur_thr == 8'd255)
            return 8'd255;
        return LEVEL_W'($urandom_range(int'(cur_thr) + 1, 255));
    endfunction

    function automatic logic [LEVEL_W-1:0] black_level();
        return LEVEL_W'($urandom_range(0, int'(cur_thr)));
    endfunction

    // a white run long enough to restart collection, kept short for big limits
    function automatic int quiet_width();
        if (cur_quiet <= 30)
            return int'(cur_quiet) + $urandom_range(1, 3);
        return $urandom_range(1, 30);
    endfunction

    function automatic void append_run(input bit white, input int width);
        repeat (width) line_q = {line_q, (white ? white_level() : black_level())};
    endfunction

    // one sample item, with an optional idle burst in front
    task automatic send_sample(input logic [LEVEL_W-1:0] lvl, input logic last);
        if (idling && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_level <= lvl;
        i_line_end     <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[k])
            send_sample(line_q[k], k == line_q.size() - 1);
    endtask

    // barcode-like lines with random content, broken ones, and raw noise
    task automatic build_line(input t_line_kind kind);
        int nsym;
        int gap_top;
        line_q.delete();
        if (kind == LINE_NOISE) begin
            repeat ($urandom_range(1, 30))
                line_q = {line_q, LEVEL_W'($urandom_range(0, 255))};
        end else begin
            gap_top = (cur_quiet == 0) ? 1 : (cur_quiet > 9 ? 9 : int'(cur_quiet));
            if (kind == LINE_CODE || $urandom_range(0, 1) == 0)
                append_run(1'b1, quiet_width());
            nsym = $urandom_range(1, 26);
            for (int k = 0; k < nsym; k++) begin
                append_run(1'b0, $urandom_range(1, 8));
                if (kind == LINE_BROKEN && $urandom_range(0, 5) == 0)
                    append_run(1'b1, quiet_width());
                else
                    append_run(1'b1, $urandom_range(1, gap_top));
            end
        end
    endtask

    // wait until every queued line result has come out, then let the pipe settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (lines_pending != 0 && guard < 20000);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_config(input logic [7:0] thr, input logic [7:0] quiet);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= bwbd_pkg::REG_LEVEL_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_index <= bwbd_pkg::REG_QUIET_GAP_LIMIT;
        i_cfg_data  <= quiet;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_thr   = thr;
        cur_quiet = quiet;
    endtask

    // one configuration phase of random lines
    task automatic run_phase(input logic [7:0] thr, input logic [7:0] quiet, input int budget,
                             input bit with_hold);
        int stop_at;
        int pick;
        i_in_valid <= 1'b0;
        wait_idle();
        program_config(thr, quiet);
        long_hold = with_hold;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 5;
                default: idle_pct = 25;
            endcase
            build_line(pick < 6 ? LINE_CODE : (pick < 8 ? LINE_BROKEN : LINE_NOISE));
            send_line();
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-sample lines at both extremes
        send_sample(8'd0, 1'b1);
        send_sample(8'd255, 1'b1);
        // levels right at the threshold, zero-length bars and gaps
        line_q = '{8'd0, 8'd129, 8'd128, 8'd255, 8'd0};
        send_line();
        // quiet gap then a short code
        line_q.delete();
        repeat (11) line_q = {line_q, 8'd255};
        line_q = {line_q, 8'd0, 8'd0, 8'd255, 8'd0, 8'd200};
        send_line();

        run_phase(8'd0, 8'd1, 280, 1'b0);
        run_phase(8'd255, 8'd255, 200, 1'b0);
        run_phase(8'($urandom_range(1, 254)), 8'd0, 250, 1'b1);
        run_phase(8'($urandom_range(1, 254)), 8'($urandom_range(1, 40)), 280, 1'b0);

        // final stretch without idling on either side
        idling = 1'b0;
        run_phase(8'd128, 8'd10, 300, 1'b0);

        i_in_valid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && lines_pending == 0) begin
            $display("PASS bar_width_barcode_decoder_unit");
        end else begin
            if (lines_pending != 0)
                $error("%0d line results never arrived", lines_pending);
            $display("FAIL bar_width_barcode_decoder_unit");
        end
        $finish;
    end

endmodule

### files.f
sv/bwbd_pkg.sv
sv/bwbd_line_core.sv
sv/bar_width_barcode_decoder_unit.sv
bench/decode_result_checker.sv
bench/testbench.sv
